// ===== src/ook_rs_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the OOK remote-socket frame sender.
// No dependencies; the interfaces, the core and the bench refer to it by scoped names.
package ook_rs_pkg;

    // Operation carried by an input transfer.
    typedef enum logic {
        OP_START = 1'b0,
        OP_TICK  = 1'b1
    } t_op;

    // Configuration register indexes (byte address = 4 * index).
    typedef enum logic [1:0] {
        REG_ONE_SYMBOL   = 2'd0,
        REG_ZERO_SYMBOL  = 2'd1,
        REG_BIT_TICKS    = 2'd2,
        REG_REPEAT_COUNT = 2'd3
    } t_reg_idx;

    localparam int HOUSE_W     = 5;
    localparam int DEVICE_W    = 3;
    localparam int SYM_W       = 8;
    localparam int BIT_TICKS_W = 16;
    localparam int REPEAT_W    = 8;
    localparam int BYTE_POS_W  = 4;
    localparam int BIT_POS_W   = 3;
    localparam int APB_ADDR_W  = 4;
    localparam int APB_DATA_W  = 32;

    // Frame layout.
    localparam int HOUSE_BYTES = 5;
    localparam int DEV_FIRST   = 5;
    localparam int DEV_LAST    = 9;
    localparam int ON_BYTE     = 10;
    localparam int OFF_BYTE    = 11;
    localparam int SYNC_BYTE   = 12;
    localparam logic [SYM_W-1:0] SYNC_VALUE = 8'd128;

    // Register reset values.
    localparam logic [SYM_W-1:0]       ONE_SYMBOL_RST   = 8'd136;
    localparam logic [SYM_W-1:0]       ZERO_SYMBOL_RST  = 8'd142;
    localparam logic [BIT_TICKS_W-1:0] BIT_TICKS_RST    = 16'd350;
    localparam logic [REPEAT_W-1:0]    REPEAT_COUNT_RST = 8'd10;

endpackage

// ===== src/ook_rs_ifs.sv =====
`timescale 1ns / 1ps
// Valid/ready channel interfaces for the frame sender's input and result streams.
// Depends on ook_rs_pkg for field widths and the operation type.
interface ook_rs_in_if;
    logic                               valid;
    logic                               ready;
    ook_rs_pkg::t_op                    op;
    logic [ook_rs_pkg::HOUSE_W-1:0]     house_code;
    logic [ook_rs_pkg::DEVICE_W-1:0]    device;
    logic                               switch_on;

    modport source (output valid, op, house_code, device, switch_on, input ready);
    modport sink   (input valid, op, house_code, device, switch_on, output ready);
endinterface

interface ook_rs_out_if;
    logic valid;
    logic ready;
    logic line_level;
    logic busy_res;
    logic frame_done;

    modport source (output valid, line_level, busy_res, frame_done, input ready);
    modport sink   (input valid, line_level, busy_res, frame_done, output ready);
endinterface

// ===== src/ook_remote_socket_frame_sender_core.sv =====
`timescale 1ns / 1ps
// Top level of the OOK remote-socket frame sender: frame state, bit timing and APB registers.
// Depends on ook_rs_pkg and the channel interfaces in ook_rs_ifs.sv.
//
// Usage:
//   The input channel carries start transfers (house code, device, on/off flag) and tick
//   transfers. A start latches the fields and restarts the frame; each tick advances the
//   serial bit timing by one. Every input transfer yields exactly one result transfer on
//   the output channel with the line level, the busy flag and the frame-done flag.
//   Four 32-bit registers on the APB port set the symbol bytes, the ticks per bit and the
//   repeat count; they are read live, so a write during a frame acts at once.
// Output register and throughput:
//   The result for an input transfer is in the output register in the cycle after it is
//   accepted. One input transfer is taken every cycle unless the output stalls; the single
//   output register is the only buffer: input ready is high while it is empty or being drained.
// Stall:
//   While the receiver holds ready low with a result pending, input ready drops and the
//   frame state is frozen, so no tick is lost and bit timing stays exact.
// Reset:
//   Synchronous active-low reset empties the output register, makes the sender idle and
//   loads the register defaults (136, 142, 350, 10).
module ook_remote_socket_frame_sender_core #(
    parameter int TICK_COUNT_BITS = 16
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    ook_rs_in_if.sink                          i_in,
    ook_rs_out_if.source                       o_out,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [ook_rs_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [ook_rs_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [ook_rs_pkg::APB_DATA_W-1:0]  prdata,
    output logic                               pready
);

    localparam int HW = (TICK_COUNT_BITS > ook_rs_pkg::BIT_TICKS_W) ?
                        TICK_COUNT_BITS : ook_rs_pkg::BIT_TICKS_W;
    localparam logic [HW-1:0] TICK_LIM = {HW{1'b1}} >> (HW - TICK_COUNT_BITS);

    // Configuration registers.
    logic [ook_rs_pkg::SYM_W-1:0]       r_one_sym;
    logic [ook_rs_pkg::SYM_W-1:0]       r_zero_sym;
    logic [ook_rs_pkg::BIT_TICKS_W-1:0] r_bit_ticks;
    logic [ook_rs_pkg::REPEAT_W-1:0]    r_repeat_count;

    // Frame state.
    logic [ook_rs_pkg::HOUSE_W-1:0]     r_house,    n_house;
    logic [ook_rs_pkg::DEVICE_W-1:0]    r_device,   n_device;
    logic                               r_on,       n_on;
    logic [ook_rs_pkg::BYTE_POS_W-1:0]  r_byte_pos, n_byte_pos;
    logic [ook_rs_pkg::BIT_POS_W-1:0]   r_bit_pos,  n_bit_pos;
    logic [TICK_COUNT_BITS-1:0]         r_tick,     n_tick;
    logic [ook_rs_pkg::REPEAT_W-1:0]    r_reps,     n_reps;
    logic                               r_active,   n_active;

    // Result register.
    logic r_out_valid;
    logic r_level, n_level;
    logic r_busy,  n_busy;
    logic r_done,  n_done;

    logic                               in_ready;
    logic                               in_xfer;
    logic                               cfg_wr;
    ook_rs_pkg::t_reg_idx               reg_idx;
    logic [ook_rs_pkg::BIT_POS_W-1:0]   house_idx;
    logic                               pos_is_one;
    logic [ook_rs_pkg::SYM_W-1:0]       frame_byte;
    logic [HW-1:0]                      hold;
    logic [HW-1:0]                      tick_inc;
    logic [ook_rs_pkg::REPEAT_W-1:0]    reps_eff;
    logic [ook_rs_pkg::REPEAT_W-1:0]    reps_inc;

    assign in_ready   = !r_out_valid || o_out.ready;
    assign in_xfer    = i_in.valid && in_ready;
    assign i_in.ready = in_ready;

    assign o_out.valid      = r_out_valid;
    assign o_out.line_level = r_level;
    assign o_out.busy_res   = r_busy;
    assign o_out.frame_done = r_done;

    // APB register file.
    assign pready  = 1'b1;
    assign reg_idx = ook_rs_pkg::t_reg_idx'(paddr[ook_rs_pkg::APB_ADDR_W-1:2]);
    assign cfg_wr  = psel && penable && pwrite;

    always_comb begin
        case (reg_idx)
            ook_rs_pkg::REG_ONE_SYMBOL:   prdata = ook_rs_pkg::APB_DATA_W'(r_one_sym);
            ook_rs_pkg::REG_ZERO_SYMBOL:  prdata = ook_rs_pkg::APB_DATA_W'(r_zero_sym);
            ook_rs_pkg::REG_BIT_TICKS:    prdata = ook_rs_pkg::APB_DATA_W'(r_bit_ticks);
            ook_rs_pkg::REG_REPEAT_COUNT: prdata = ook_rs_pkg::APB_DATA_W'(r_repeat_count);
            default:                      prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_one_sym      <= ook_rs_pkg::ONE_SYMBOL_RST;
            r_zero_sym     <= ook_rs_pkg::ZERO_SYMBOL_RST;
            r_bit_ticks    <= ook_rs_pkg::BIT_TICKS_RST;
            r_repeat_count <= ook_rs_pkg::REPEAT_COUNT_RST;
        end else if (cfg_wr) begin
            case (reg_idx)
                ook_rs_pkg::REG_ONE_SYMBOL:
                    r_one_sym <= pwdata[ook_rs_pkg::SYM_W-1:0];
                ook_rs_pkg::REG_ZERO_SYMBOL:
                    r_zero_sym <= pwdata[ook_rs_pkg::SYM_W-1:0];
                ook_rs_pkg::REG_BIT_TICKS:
                    r_bit_ticks <= pwdata[ook_rs_pkg::BIT_TICKS_W-1:0];
                ook_rs_pkg::REG_REPEAT_COUNT:
                    r_repeat_count <= pwdata[ook_rs_pkg::REPEAT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Current frame byte, built from the latched fields and the live symbol registers.
    assign house_idx = ook_rs_pkg::BIT_POS_W'(ook_rs_pkg::HOUSE_BYTES - 1)
                       - r_byte_pos[ook_rs_pkg::BIT_POS_W-1:0];

    always_comb begin
        pos_is_one = 1'b0;
        frame_byte = '0;
        if (r_byte_pos < ook_rs_pkg::BYTE_POS_W'(ook_rs_pkg::HOUSE_BYTES)) begin
            pos_is_one = r_house[house_idx];
            frame_byte = pos_is_one ? r_one_sym : r_zero_sym;
        end else if (r_byte_pos <= ook_rs_pkg::BYTE_POS_W'(ook_rs_pkg::DEV_LAST)) begin
            // Device codes above four match no position, so every device byte is a zero.
            pos_is_one = ({1'b0, r_device} ==
                          (r_byte_pos - ook_rs_pkg::BYTE_POS_W'(ook_rs_pkg::DEV_FIRST)));
            frame_byte = pos_is_one ? r_one_sym : r_zero_sym;
        end else if (r_byte_pos == ook_rs_pkg::BYTE_POS_W'(ook_rs_pkg::ON_BYTE)) begin
            pos_is_one = r_on;
            frame_byte = pos_is_one ? r_one_sym : r_zero_sym;
        end else if (r_byte_pos == ook_rs_pkg::BYTE_POS_W'(ook_rs_pkg::OFF_BYTE)) begin
            pos_is_one = !r_on;
            frame_byte = pos_is_one ? r_one_sym : r_zero_sym;
        end else if (r_byte_pos == ook_rs_pkg::BYTE_POS_W'(ook_rs_pkg::SYNC_BYTE)) begin
            frame_byte = ook_rs_pkg::SYNC_VALUE;
        end
    end

    // Hold time per bit: zero counts as one, and it saturates at the counter's range.
    always_comb begin
        hold = HW'(r_bit_ticks);
        if (hold == '0) begin
            hold = HW'(1);
        end
        if (hold > TICK_LIM) begin
            hold = TICK_LIM;
        end
    end

    assign tick_inc = HW'(r_tick) + HW'(1);
    assign reps_eff = (r_repeat_count == '0) ? ook_rs_pkg::REPEAT_W'(1) : r_repeat_count;
    assign reps_inc = r_reps + ook_rs_pkg::REPEAT_W'(1);

    always_comb begin
        n_house    = r_house;
        n_device   = r_device;
        n_on       = r_on;
        n_byte_pos = r_byte_pos;
        n_bit_pos  = r_bit_pos;
        n_tick     = r_tick;
        n_reps     = r_reps;
        n_active   = r_active;
        n_level    = 1'b0;
        n_busy     = 1'b0;
        n_done     = 1'b0;
        if (i_in.op == ook_rs_pkg::OP_START) begin
            // A start also drops any frame in flight.
            n_house    = i_in.house_code;
            n_device   = i_in.device;
            n_on       = i_in.switch_on;
            n_byte_pos = '0;
            n_bit_pos  = '0;
            n_tick     = '0;
            n_reps     = '0;
            n_active   = 1'b1;
            n_busy     = 1'b1;
        end else if (r_active) begin
            n_level = frame_byte[ook_rs_pkg::BIT_POS_W'(ook_rs_pkg::SYM_W - 1) - r_bit_pos];
            n_busy  = 1'b1;
            n_tick  = tick_inc[TICK_COUNT_BITS-1:0];
            if (tick_inc >= hold) begin
                n_tick    = '0;
                n_bit_pos = r_bit_pos + ook_rs_pkg::BIT_POS_W'(1);
                if (r_bit_pos == '1) begin
                    n_byte_pos = r_byte_pos + ook_rs_pkg::BYTE_POS_W'(1);
                    if (r_byte_pos == '1) begin
                        n_reps = reps_inc;
                        if (reps_inc >= reps_eff) begin
                            n_active = 1'b0;
                            n_reps   = '0;
                            n_done   = 1'b1;
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_house    <= '0;
            r_device   <= '0;
            r_on       <= 1'b0;
            r_byte_pos <= '0;
            r_bit_pos  <= '0;
            r_tick     <= '0;
            r_reps     <= '0;
            r_active   <= 1'b0;
        end else if (in_xfer) begin
            r_house    <= n_house;
            r_device   <= n_device;
            r_on       <= n_on;
            r_byte_pos <= n_byte_pos;
            r_bit_pos  <= n_bit_pos;
            r_tick     <= n_tick;
            r_reps     <= n_reps;
            r_active   <= n_active;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_xfer) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_level <= n_level;
            r_busy  <= n_busy;
            r_done  <= n_done;
        end
    end

endmodule

// ===== src/ook_rs_checker.sv =====
`timescale 1ns / 1ps
// Port-level checks for the OOK remote-socket frame sender, with the bind that attaches them.
// Depends on ook_remote_socket_frame_sender_core and its channel interfaces.
module ook_rs_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_in_valid,
    input logic i_in_ready,
    input logic i_out_valid,
    input logic i_out_ready,
    input logic i_out_level,
    input logic i_out_busy,
    input logic i_out_done
);

    // Every accepted input transfer leaves a result waiting in the next cycle.
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> i_out_valid)
        else $error("accepted input produced no result");

    // The end of a frame is always reported as part of a busy transmission.
    a_done_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_done |-> i_out_busy)
        else $error("frame_done without busy_res");

    // The line is low whenever no transmission is running.
    a_idle_low: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_busy |-> !i_out_level)
        else $error("line high while idle");

    // A stalled result holds its value.
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            i_out_valid && $stable(i_out_level) && $stable(i_out_busy) && $stable(i_out_done))
        else $error("stalled result changed");

    // Reset empties the result register.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

endmodule

bind ook_remote_socket_frame_sender_core ook_rs_checker u_ook_rs_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_level (o_out.line_level),
    .i_out_busy  (o_out.busy_res),
    .i_out_done  (o_out.frame_done)
);

// ===== tb/sv/ook_remote_socket_frame_sender_core_tb.sv =====
`timescale 1ns / 1ps
// Self-checking bench for ook_remote_socket_frame_sender_core: a directed table, then random frames.
// Depends on ook_rs_pkg, the channel interfaces in ook_rs_ifs.sv and the core itself.
module ook_remote_socket_frame_sender_core_tb;

    localparam int TICK_BITS = 16;
    localparam longint unsigned TICK_MAX = (64'd1 << TICK_BITS) - 64'd1;
    localparam int FRAME_BYTES = 16;
    localparam int FRAME_BITS = FRAME_BYTES * ook_rs_pkg::SYM_W;
    localparam int RANDOM_ITEMS = 440;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int DIR_ROWS = 21;
    localparam int CFG_SWAP_ROW = 7;

    typedef struct packed {
        logic level;
        logic busy;
        logic done;
    } t_line_res;

    typedef struct packed {
        ook_rs_pkg::t_op                 op;
        logic [ook_rs_pkg::HOUSE_W-1:0]  house;
        logic [ook_rs_pkg::DEVICE_W-1:0] dev;
        logic                            on_flag;
        logic                            typed_in;
        t_line_res                       want;
    } t_dir_row;

    logic                              i_clk = 1'b0;
    logic                              i_rst_n;
    logic                              psel;
    logic                              penable;
    logic                              pwrite;
    logic [ook_rs_pkg::APB_ADDR_W-1:0] paddr;
    logic [ook_rs_pkg::APB_DATA_W-1:0] pwdata;
    logic [ook_rs_pkg::APB_DATA_W-1:0] prdata;
    logic                              pready;

    ook_rs_in_if  in_ch();
    ook_rs_out_if out_ch();

    // Register copies and frame state of the serializer model.
    logic [ook_rs_pkg::SYM_W-1:0]       cfg_one;
    logic [ook_rs_pkg::SYM_W-1:0]       cfg_zero;
    logic [ook_rs_pkg::BIT_TICKS_W-1:0] cfg_bit_ticks;
    logic [ook_rs_pkg::REPEAT_W-1:0]    cfg_repeat;
    logic [ook_rs_pkg::HOUSE_W-1:0]     lat_house;
    logic [ook_rs_pkg::DEVICE_W-1:0]    lat_dev;
    logic                               lat_on;
    int unsigned                        byte_pos;
    int unsigned                        bit_pos;
    int unsigned                        reps_done;
    longint unsigned                    hold_cnt;
    bit                                 tx_active;

    t_line_res expected_lines[$];
    int        n_errors = 0;
    bit        steady_sender = 1'b0;

    // Ticks, idle ticks, restarts, devices above four and live register changes.
    t_dir_row directed_rows [DIR_ROWS] = '{
        '{ook_rs_pkg::OP_TICK,  5'd0,  3'd0, 1'b0, 1'b1, 3'b000},
        '{ook_rs_pkg::OP_TICK,  5'd31, 3'd7, 1'b1, 1'b1, 3'b000},
        '{ook_rs_pkg::OP_START, 5'd31, 3'd0, 1'b1, 1'b1, 3'b010},
        '{ook_rs_pkg::OP_TICK,  5'd0,  3'd0, 1'b0, 1'b0, 3'b000},
        '{ook_rs_pkg::OP_TICK,  5'd0,  3'd0, 1'b0, 1'b0, 3'b000},
        '{ook_rs_pkg::OP_START, 5'd0,  3'd4, 1'b0, 1'b1, 3'b010},
        '{ook_rs_pkg::OP_TICK,  5'd0,  3'd0, 1'b0, 1'b0, 3'b000},
        '{ook_rs_pkg::OP_TICK,  5'd0,  3'd0, 1'b0, 1'b0, 3'b000},
        '{ook_rs_pkg::OP_START, 5'd21, 3'd7, 1'b1, 1'b1, 3'b010},
        '{ook_rs_pkg::OP_TICK,  5'd0,  3'd0, 1'b0, 1'b0, 3'b000},
        '{ook_rs_pkg::OP_TICK,  5'd0,  3'd0, 1'b0, 1'b0, 3'b000},
        '{ook_rs_pkg::OP_TICK,  5'd0,  3'd0, 1'b0, 1'b0, 3'b000},
        '{ook_rs_pkg::OP_TICK,  5'd0,  3'd0, 1'b0, 1'b0, 3'b000},
        '{ook_rs_pkg::OP_TICK,  5'd0,  3'd0, 1'b0, 1'b0, 3'b000},
        '{ook_rs_pkg::OP_TICK,  5'd0,  3'd0, 1'b0, 1'b0, 3'b000},
        '{ook_rs_pkg::OP_START, 5'd10, 3'd5, 1'b0, 1'b1, 3'b010},
        '{ook_rs_pkg::OP_TICK,  5'd0,  3'd0, 1'b0, 1'b0, 3'b000},
        '{ook_rs_pkg::OP_TICK,  5'd0,  3'd0, 1'b0, 1'b0, 3'b000},
        '{ook_rs_pkg::OP_TICK,  5'd0,  3'd0, 1'b0, 1'b0, 3'b000},
        '{ook_rs_pkg::OP_START, 5'd0,  3'd6, 1'b1, 1'b1, 3'b010},
        '{ook_rs_pkg::OP_TICK,  5'd31, 3'd7, 1'b1, 1'b0, 3'b000}
    };

    ook_remote_socket_frame_sender_core #(
        .TICK_COUNT_BITS(TICK_BITS)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #10 i_clk = ~i_clk;

    function automatic logic [ook_rs_pkg::SYM_W-1:0] sym_for(logic one);
        return one ? cfg_one : cfg_zero;
    endfunction

    // Zero means one tick; anything beyond the counter saturates.
    function automatic longint unsigned hold_len();
        longint unsigned t;
        t = (cfg_bit_ticks == 0) ? 64'd1 : 64'(cfg_bit_ticks);
        return (t > TICK_MAX) ? TICK_MAX : t;
    endfunction

    function automatic t_line_res advance_sender(ook_rs_pkg::t_op op,
                                                logic [ook_rs_pkg::HOUSE_W-1:0] house,
                                                logic [ook_rs_pkg::DEVICE_W-1:0] dev,
                                                logic on_flag);
        t_line_res                    res;
        logic [ook_rs_pkg::SYM_W-1:0] cur;
        int unsigned                  reps;
        res = '0;
        if (op == ook_rs_pkg::OP_START) begin
            lat_house = house;
            lat_dev = dev;
            lat_on = on_flag;
            byte_pos = 0;
            bit_pos = 0;
            hold_cnt = 0;
            reps_done = 0;
            tx_active = 1'b1;
            res.busy = 1'b1;
        end else if (tx_active) begin
            if (byte_pos < ook_rs_pkg::HOUSE_BYTES) begin
                cur = sym_for(lat_house[ook_rs_pkg::HOUSE_W - 1 - byte_pos]);
            end else if (byte_pos <= ook_rs_pkg::DEV_LAST) begin
                cur = sym_for(32'(lat_dev) == byte_pos - ook_rs_pkg::DEV_FIRST);
            end else if (byte_pos == ook_rs_pkg::ON_BYTE) begin
                cur = sym_for(lat_on);
            end else if (byte_pos == ook_rs_pkg::OFF_BYTE) begin
                cur = sym_for(!lat_on);
            end else if (byte_pos == ook_rs_pkg::SYNC_BYTE) begin
                cur = ook_rs_pkg::SYNC_VALUE;
            end else begin
                cur = '0;
            end
            reps = (cfg_repeat == 0) ? 1 : 32'(cfg_repeat);
            res.level = cur[ook_rs_pkg::SYM_W - 1 - bit_pos];
            res.busy = 1'b1;
            hold_cnt++;
            if (hold_cnt >= hold_len()) begin
                hold_cnt = 0;
                bit_pos++;
                if (bit_pos >= ook_rs_pkg::SYM_W) begin
                    bit_pos = 0;
                    byte_pos++;
                    if (byte_pos >= FRAME_BYTES) begin
                        byte_pos = 0;
                        reps_done++;
                        if (reps_done >= reps) begin
                            tx_active = 1'b0;
                            reps_done = 0;
                            res.done = 1'b1;
                        end
                    end
                end
            end
        end
        return res;
    endfunction

    // Presents one item, waits for its transfer and records what it should produce.
    task automatic send_item(ook_rs_pkg::t_op op, logic [ook_rs_pkg::HOUSE_W-1:0] house,
                             logic [ook_rs_pkg::DEVICE_W-1:0] dev, logic on_flag,
                             logic typed_in = 1'b0, t_line_res want = '0);
        int        gap;
        int        r;
        t_line_res predicted;
        r = $urandom_range(0, 99);
        if (steady_sender || r < 65) begin
            gap = 0;
        end else if (r < 93) begin
            gap = $urandom_range(1, 3);
        end else begin
            gap = $urandom_range(8, 30);
        end
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.op <= op;
        in_ch.house_code <= house;
        in_ch.device <= dev;
        in_ch.switch_on <= on_flag;
        do @(posedge i_clk); while (!in_ch.ready);
        predicted = advance_sender(op, house, dev, on_flag);
        expected_lines.push_back(typed_in ? want : predicted);
    endtask

    task automatic send_random(ook_rs_pkg::t_op op);
        send_item(op, ook_rs_pkg::HOUSE_W'($urandom_range(0, 31)),
                  ook_rs_pkg::DEVICE_W'($urandom_range(0, 7)), 1'($urandom_range(0, 1)));
    endtask

    // Drops valid and waits until every outstanding result has been taken.
    task automatic settle();
        in_ch.valid <= 1'b0;
        do @(posedge i_clk); while (expected_lines.size() != 0);
    endtask

    task automatic write_reg(ook_rs_pkg::t_reg_idx idx,
                             logic [ook_rs_pkg::APB_DATA_W-1:0] data);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        case (idx)
            ook_rs_pkg::REG_ONE_SYMBOL: cfg_one = data[ook_rs_pkg::SYM_W-1:0];
            ook_rs_pkg::REG_ZERO_SYMBOL: cfg_zero = data[ook_rs_pkg::SYM_W-1:0];
            ook_rs_pkg::REG_BIT_TICKS: cfg_bit_ticks = data[ook_rs_pkg::BIT_TICKS_W-1:0];
            ook_rs_pkg::REG_REPEAT_COUNT: cfg_repeat = data[ook_rs_pkg::REPEAT_W-1:0];
            default: ;
        endcase
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic compare_bit(string field, logic want_bit, logic got_bit);
        if (got_bit !== want_bit) begin
            $display("%0t: %s mismatch, expected %0b actual %0b", $time, field, want_bit,
                     got_bit);
            n_errors++;
        end
    endtask

    // Result side: random ready with short and long stalls, checked on every transfer.
    initial begin
        int        run_left;
        int        r;
        logic      rdy;
        t_line_res want;
        run_left = 0;
        rdy = 1'b0;
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && out_ch.valid && out_ch.ready) begin
                if (expected_lines.size() == 0) begin
                    $display("%0t: result transfer with nothing expected", $time);
                    n_errors++;
                end else begin
                    want = expected_lines.pop_front();
                    compare_bit("line_level", want.level, out_ch.line_level);
                    compare_bit("busy_res", want.busy, out_ch.busy_res);
                    compare_bit("frame_done", want.done, out_ch.frame_done);
                end
            end
            if (run_left == 0) begin
                r = $urandom_range(0, 99);
                if (r < 55) begin
                    rdy = 1'b1;
                    run_left = $urandom_range(1, 40);
                end else if (r < 92) begin
                    rdy = 1'b0;
                    run_left = $urandom_range(1, 3);
                end else begin
                    rdy = 1'b0;
                    run_left = $urandom_range(10, 40);
                end
            end
            run_left--;
            out_ch.ready <= rdy;
        end
    end

    initial begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || psel) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
        end
        $display("%0t: no transfer for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("ook_remote_socket_frame_sender_core_tb: errors");
        $finish;
    end

    initial begin
        int                                sent;
        int                                n_ticks;
        int                                r;
        longint unsigned                   frame_len;
        logic [ook_rs_pkg::APB_DATA_W-1:0] data;
        bit                                first_phase;

        i_rst_n <= 1'b0;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= '0;
        pwdata <= '0;
        in_ch.valid <= 1'b0;
        in_ch.op <= ook_rs_pkg::OP_TICK;
        in_ch.house_code <= '0;
        in_ch.device <= '0;
        in_ch.switch_on <= 1'b0;

        cfg_one = ook_rs_pkg::ONE_SYMBOL_RST;
        cfg_zero = ook_rs_pkg::ZERO_SYMBOL_RST;
        cfg_bit_ticks = ook_rs_pkg::BIT_TICKS_RST;
        cfg_repeat = ook_rs_pkg::REPEAT_COUNT_RST;
        lat_house = '0;
        lat_dev = '0;
        lat_on = 1'b0;
        byte_pos = 0;
        bit_pos = 0;
        hold_cnt = 0;
        reps_done = 0;
        tx_active = 1'b0;

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int i = 0; i < DIR_ROWS; i++) begin
            if (i == CFG_SWAP_ROW) begin
                // Extremes with junk above each register's width, written mid-frame.
                settle();
                write_reg(ook_rs_pkg::REG_ONE_SYMBOL, 32'h1234_56FF);
                write_reg(ook_rs_pkg::REG_ZERO_SYMBOL, 32'hFFFF_FF00);
                write_reg(ook_rs_pkg::REG_BIT_TICKS, 32'hABCD_0000);
                write_reg(ook_rs_pkg::REG_REPEAT_COUNT, 32'h0000_1200);
            end
            send_item(directed_rows[i].op, directed_rows[i].house, directed_rows[i].dev,
                      directed_rows[i].on_flag, directed_rows[i].typed_in,
                      directed_rows[i].want);
        end

        sent = 0;
        first_phase = 1'b1;
        while (sent < RANDOM_ITEMS) begin
            settle();
            if (first_phase || $urandom_range(0, 1) == 1) begin
                data = $urandom();
                r = $urandom_range(0, 3);
                if (r == 0) data[ook_rs_pkg::SYM_W-1:0] = '0;
                else if (r == 1) data[ook_rs_pkg::SYM_W-1:0] = '1;
                write_reg(ook_rs_pkg::REG_ONE_SYMBOL, data);
            end
            if (first_phase || $urandom_range(0, 1) == 1) begin
                data = $urandom();
                r = $urandom_range(0, 3);
                if (r == 0) data[ook_rs_pkg::SYM_W-1:0] = '0;
                else if (r == 1) data[ook_rs_pkg::SYM_W-1:0] = '1;
                write_reg(ook_rs_pkg::REG_ZERO_SYMBOL, data);
            end
            // Short hold times dominate so that whole frames finish within the run.
            if (first_phase || $urandom_range(0, 1) == 1) begin
                data = $urandom();
                r = $urandom_range(0, 19);
                if (r < 12) begin
                    data[ook_rs_pkg::BIT_TICKS_W-1:0] =
                        ook_rs_pkg::BIT_TICKS_W'($urandom_range(0, 1));
                end else if (r < 16) begin
                    data[ook_rs_pkg::BIT_TICKS_W-1:0] =
                        ook_rs_pkg::BIT_TICKS_W'($urandom_range(2, 3));
                end else if (r == 16) begin
                    data[ook_rs_pkg::BIT_TICKS_W-1:0] = '1;
                end else if (r == 17) begin
                    data[ook_rs_pkg::BIT_TICKS_W-1:0] =
                        ook_rs_pkg::BIT_TICKS_W'($urandom_range(4, 12));
                end
                write_reg(ook_rs_pkg::REG_BIT_TICKS, data);
            end
            if (first_phase || $urandom_range(0, 1) == 1) begin
                data = $urandom();
                r = $urandom_range(0, 19);
                if (r < 14) begin
                    data[ook_rs_pkg::REPEAT_W-1:0] = ook_rs_pkg::REPEAT_W'($urandom_range(0, 1));
                end else if (r < 17) begin
                    data[ook_rs_pkg::REPEAT_W-1:0] = ook_rs_pkg::REPEAT_W'(2);
                end else if (r == 17) begin
                    data[ook_rs_pkg::REPEAT_W-1:0] = '1;
                end
                write_reg(ook_rs_pkg::REG_REPEAT_COUNT, data);
            end
            first_phase = 1'b0;
            steady_sender = ($urandom_range(0, 3) == 0);

            if ($urandom_range(0, 9) < 8) begin
                send_random(ook_rs_pkg::OP_START);
                sent++;
                frame_len = 64'(FRAME_BITS) * hold_len() *
                            ((cfg_repeat == 0) ? 64'd1 : 64'(cfg_repeat));
                if (frame_len > 280) begin
                    n_ticks = $urandom_range(20, 80);
                end else begin
                    n_ticks = int'(frame_len) + $urandom_range(0, 4);
                end
                for (int k = 0; k < n_ticks; k++) begin
                    if ($urandom_range(0, 199) == 0) send_random(ook_rs_pkg::OP_START);
                    else send_random(ook_rs_pkg::OP_TICK);
                end
                sent += n_ticks;
            end else begin
                n_ticks = $urandom_range(5, 30);
                for (int k = 0; k < n_ticks; k++) begin
                    send_random(($urandom_range(0, 1) == 1) ? ook_rs_pkg::OP_TICK
                                                             : ook_rs_pkg::OP_START);
                end
                sent += n_ticks;
            end
        end

        settle();
        repeat (4) @(posedge i_clk);
        if (n_errors == 0) begin
            $display("ook_remote_socket_frame_sender_core_tb: clean");
        end else begin
            $display("ook_remote_socket_frame_sender_core_tb: errors");
        end
        $finish;
    end

endmodule

// ===== files.f =====
src/ook_rs_pkg.sv
src/ook_rs_ifs.sv
src/ook_remote_socket_frame_sender_core.sv
src/ook_rs_checker.sv
tb/sv/ook_remote_socket_frame_sender_core_tb.sv
